/* sv/dtnp_pkg.sv */
// Shared constants, codes and the power-of-ten table for the decimal text parser.
package dtnp_pkg;

    localparam int DEF_FRAC_DIGITS = 6;
    localparam int DEF_FRAC_BITS   = 16;

    // Fraction accumulator holds at most nine decimal digits.
    localparam int FRAC_W = 30;
    localparam int CNT_W  = 4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_END     = 2'd2;

    localparam logic [1:0] MODE_INT = 2'd0;
    localparam logic [1:0] MODE_FIX = 2'd1;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    function automatic logic [FRAC_W-1:0] pow10(input logic [CNT_W-1:0] c);
        logic [FRAC_W-1:0] r;
        begin
            case (c)
                4'd0: r = FRAC_W'(1);
                4'd1: r = FRAC_W'(10);
                4'd2: r = FRAC_W'(100);
                4'd3: r = FRAC_W'(1000);
                4'd4: r = FRAC_W'(10000);
                4'd5: r = FRAC_W'(100000);
                4'd6: r = FRAC_W'(1000000);
                4'd7: r = FRAC_W'(10000000);
                4'd8: r = FRAC_W'(100000000);
                default: r = FRAC_W'(1000000000);
            endcase
            return r;
        end
    endfunction

endpackage

/* sv/decimal_text_number_parser.sv */
// Streaming decimal text parser: sequencer, token registers and result buffering.
//
//  channel | direction | ports                                          | handshake
//  --------+-----------+------------------------------------------------+----------------
//  s_      | in        | s_text_byte, s_end_of_text, s_mode             | s_valid/s_ready
//  m_      | out       | m_status, m_number, m_final_of_step            | m_valid/m_ready
//
// Each byte passes through accept, token step, a value beat when the byte closes a token,
// start-of-token step and a flush; no new byte is taken until the flush is done.
// With end of text set, the closing value and the end-of-data beat are added.
// Each fixed-point token that ends also passes through the restoring divider.
// Reset is synchronous on aresetn low and returns the parser to whitespace skipping.
// A result waits in a one-deep holding register so that its final flag is known; the
// sequencer stops while both it and the output register are full and m_ready is low.
module decimal_text_number_parser
    import dtnp_pkg::*;
#(
    parameter int FRAC_DIGITS = DEF_FRAC_DIGITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_text_byte,
    input  logic               s_end_of_text,
    input  logic [1:0]         s_mode,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_number,
    output logic               m_final_of_step
);

    localparam int MAG_W = 32 + FRAC_BITS;
    localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(64'h8000_0000);
    localparam logic [MAG_W-1:0] POS_LIM = MAG_W'(64'h7FFF_FFFF);

    typedef enum logic [3:0] {
        S_IDLE, S_ACCEPT, S_START, S_EOT, S_DSTART, S_DIV, S_VALUE, S_END, S_FLUSH
    } state_t;

    typedef enum logic [1:0] {PH_SKIP, PH_SIGN, PH_INT, PH_FRAC} phase_t;

    state_t            state_reg;
    phase_t            phase_reg;
    logic [1:0]        tmode_reg;
    logic              neg_reg;
    logic [31:0]       int_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [CNT_W-1:0]  fcnt_reg;
    logic              at_eot_reg;

    logic [7:0]        byte_reg;
    logic              eot_reg;
    logic [1:0]        mode_reg;

    logic              held_valid_reg;
    logic [1:0]        held_status_reg;
    logic [31:0]       held_number_reg;

    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [31:0]       m_number_reg;
    logic              m_final_reg;

    logic              is_digit;
    logic              is_space;
    logic              start_ok;
    logic [3:0]        digit;
    logic [35:0]       int_acc;
    logic [31:0]       int_sat;
    logic [FRAC_W+3:0] frac_acc;

    logic              div_start;
    logic [FRAC_BITS-1:0] div_q;
    logic              div_done;

    logic [MAG_W-1:0]  mag;
    logic [MAG_W-1:0]  mag_sat;
    logic [31:0]       value;

    logic              out_free;
    logic              can_emit;
    logic              emit_req;
    logic [1:0]        emit_status;
    logic [31:0]       emit_number;
    logic              emit_fire;

    always_comb begin
        is_digit = (byte_reg >= CH_0) && (byte_reg <= CH_9);
        is_space = byte_reg inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
        start_ok = ((mode_reg == MODE_INT) || (mode_reg == MODE_FIX)) &&
                   (is_digit || (byte_reg == CH_MINUS) ||
                    ((byte_reg == CH_PLUS) && (mode_reg == MODE_FIX)));
        digit    = byte_reg[3:0] - CH_0[3:0];
        int_acc  = ({4'd0, int_reg} << 3) + ({4'd0, int_reg} << 1) + 36'(digit);
        int_sat  = (int_acc > 36'h8000_0000) ? 32'h8000_0000 : int_acc[31:0];
        frac_acc = ({4'd0, frac_reg} << 3) + ({4'd0, frac_reg} << 1) + (FRAC_W + 4)'(digit);
    end

    // Token value: integer part plus, in fixed-point mode, the scaled fraction, clamped by sign.
    always_comb begin
        if (tmode_reg == MODE_FIX) begin
            mag = (MAG_W'(int_reg) << FRAC_BITS) + MAG_W'(div_q);
        end else begin
            mag = MAG_W'(int_reg);
        end
        if (neg_reg) begin
            mag_sat = (mag > NEG_LIM) ? NEG_LIM : mag;
            value   = 32'd0 - mag_sat[31:0];
        end else begin
            mag_sat = (mag > POS_LIM) ? POS_LIM : mag;
            value   = mag_sat[31:0];
        end
    end

    always_comb begin
        emit_req    = 1'b0;
        emit_status = ST_NOMATCH;
        emit_number = '0;
        case (state_reg)
            S_ACCEPT: emit_req = (phase_reg == PH_SIGN) && !is_digit;
            S_START:  emit_req = !is_space && !start_ok;
            S_EOT:    emit_req = eot_reg && (phase_reg == PH_SIGN);
            S_VALUE: begin
                emit_req    = 1'b1;
                emit_status = ST_OK;
                emit_number = value;
            end
            S_END: begin
                emit_req    = 1'b1;
                emit_status = ST_END;
            end
            default: emit_req = 1'b0;
        endcase
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign can_emit  = !held_valid_reg || out_free;
    assign emit_fire = emit_req && can_emit;
    assign div_start = (state_reg == S_DSTART);

    dtnp_div #(
        .QW(FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (frac_reg),
        .divisor  (pow10(fcnt_reg)),
        .quotient (div_q),
        .done     (div_done)
    );

    always_ff @(posedge aclk) begin
        if (m_ready) begin
            m_valid_reg <= 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    byte_reg   <= s_text_byte;
                    eot_reg    <= s_end_of_text;
                    mode_reg   <= s_mode;
                    at_eot_reg <= 1'b0;
                    state_reg  <= S_ACCEPT;
                end
            end
            S_ACCEPT: begin
                case (phase_reg)
                    PH_SIGN: begin
                        if (is_digit) begin
                            int_reg   <= 32'(digit);
                            phase_reg <= PH_INT;
                            state_reg <= S_EOT;
                        end else if (emit_fire) begin
                            state_reg <= S_START;
                        end
                    end
                    PH_INT: begin
                        if (is_digit) begin
                            int_reg   <= int_sat;
                            state_reg <= S_EOT;
                        end else if ((byte_reg == CH_DOT) && (tmode_reg == MODE_FIX)) begin
                            phase_reg <= PH_FRAC;
                            state_reg <= S_EOT;
                        end else begin
                            state_reg <= (tmode_reg == MODE_FIX) ? S_DSTART : S_VALUE;
                        end
                    end
                    PH_FRAC: begin
                        if (is_digit) begin
                            if (fcnt_reg < CNT_W'(FRAC_DIGITS)) begin
                                frac_reg <= frac_acc[FRAC_W-1:0];
                                fcnt_reg <= fcnt_reg + CNT_W'(1);
                            end
                            state_reg <= S_EOT;
                        end else begin
                            state_reg <= S_DSTART;
                        end
                    end
                    default: state_reg <= S_START;
                endcase
            end
            S_START: begin
                if (is_space) begin
                    state_reg <= S_EOT;
                end else if (start_ok) begin
                    tmode_reg <= mode_reg;
                    if (is_digit) begin
                        int_reg   <= 32'(digit);
                        phase_reg <= PH_INT;
                    end else begin
                        neg_reg   <= (byte_reg == CH_MINUS);
                        phase_reg <= PH_SIGN;
                    end
                    state_reg <= S_EOT;
                end else if (emit_fire) begin
                    state_reg <= S_EOT;
                end
            end
            S_EOT: begin
                if (!eot_reg) begin
                    state_reg <= S_FLUSH;
                end else begin
                    at_eot_reg <= 1'b1;
                    case (phase_reg)
                        PH_INT, PH_FRAC: begin
                            state_reg <= (tmode_reg == MODE_FIX) ? S_DSTART : S_VALUE;
                        end
                        PH_SIGN: begin
                            if (emit_fire) begin
                                state_reg <= S_END;
                            end
                        end
                        default: state_reg <= S_END;
                    endcase
                end
            end
            S_DSTART: state_reg <= S_DIV;
            S_DIV: begin
                if (div_done) begin
                    state_reg <= S_VALUE;
                end
            end
            S_VALUE: begin
                if (emit_fire) begin
                    state_reg <= at_eot_reg ? S_END : S_START;
                end
            end
            S_END: begin
                if (emit_fire) begin
                    state_reg <= S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!held_valid_reg) begin
                    state_reg <= S_IDLE;
                end else if (out_free) begin
                    m_valid_reg    <= 1'b1;
                    m_status_reg   <= held_status_reg;
                    m_number_reg   <= held_number_reg;
                    m_final_reg    <= 1'b1;
                    held_valid_reg <= 1'b0;
                    state_reg      <= S_IDLE;
                end
            end
            default: state_reg <= S_IDLE;
        endcase

        // Every result ends the current token; the previous held beat moves to the output.
        if (emit_fire) begin
            if (held_valid_reg) begin
                m_valid_reg  <= 1'b1;
                m_status_reg <= held_status_reg;
                m_number_reg <= held_number_reg;
                m_final_reg  <= 1'b0;
            end
            held_valid_reg  <= 1'b1;
            held_status_reg <= emit_status;
            held_number_reg <= emit_number;
            phase_reg       <= PH_SKIP;
            tmode_reg       <= MODE_INT;
            neg_reg         <= 1'b0;
            int_reg         <= '0;
            frac_reg        <= '0;
            fcnt_reg        <= '0;
        end

        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_SKIP;
            tmode_reg      <= MODE_INT;
            neg_reg        <= 1'b0;
            int_reg        <= '0;
            frac_reg       <= '0;
            fcnt_reg       <= '0;
            at_eot_reg     <= 1'b0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_number        = m_number_reg;
    assign m_final_of_step = m_final_reg;

    a_nonok_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_number == 32'sd0))
        else $error("non-ok result carries a non-zero number");

    a_end_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_END) |-> m_final_of_step)
        else $error("end-of-data beat is not the last of its byte");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !held_valid_reg)
        else $error("new byte taken while a result is still held");

    a_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

endmodule

/* sv/dtnp_div.sv */
// Restoring divider producing QW quotient bits of (dividend << QW) / divisor, one per cycle.
module dtnp_div
    import dtnp_pkg::*;
#(
    parameter int QW = DEF_FRAC_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [FRAC_W-1:0] dividend,
    input  logic [FRAC_W-1:0] divisor,
    output logic [QW-1:0]     quotient,
    output logic              done
);

    localparam int CW = $clog2(QW + 1);

    logic [FRAC_W-1:0] rem_reg;
    logic [FRAC_W-1:0] dsr_reg;
    logic [QW-1:0]     quo_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [FRAC_W:0]   rem_shift;
    logic              q_bit;
    logic [FRAC_W:0]   rem_diff;

    // The dividend is always below the divisor, so the remainder stays in FRAC_W bits.
    assign rem_shift = {rem_reg, 1'b0};
    assign q_bit     = rem_shift >= {1'b0, dsr_reg};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        if (start) begin
            rem_reg  <= dividend;
            dsr_reg  <= divisor;
            cnt_reg  <= CW'(QW);
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            rem_reg <= q_bit ? rem_diff[FRAC_W-1:0] : rem_shift[FRAC_W-1:0];
            quo_reg <= {quo_reg[QW-2:0], q_bit};
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule
